// ===== rtl/core/sprite_line_selector_unit_assert.svh =====
// Assertion macros shared by the sprite line selector.
`ifndef SPRITE_LINE_SELECTOR_UNIT_ASSERT_SVH
`define SPRITE_LINE_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLSEL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLSEL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slsel_pkg.sv =====
`timescale 1ns / 1ps

package slsel_pkg;

    localparam int TABLE_ENTRIES = 40;
    localparam int MAX_PER_LINE  = 10;
    localparam int LINE_OFFSET   = 16;
    localparam int TALL_HEIGHT   = 16;
    localparam int SHORT_HEIGHT  = 8;
    localparam int TABLE_BYTES   = TABLE_ENTRIES * 4;

    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 8;
    localparam int LINE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 4;
    // Line plus offset and Y plus height both fit in one extra bit.
    localparam int POS_W   = LINE_W + 1;

    localparam int ENTRY_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IDX_CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LIST_W    = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    localparam logic [1:0] LANE_Y = 2'd0;
    localparam logic [1:0] LANE_X = 2'd1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] attr_addr;
        logic [DATA_W-1:0] attr_data;
        logic [LINE_W-1:0] line;
    } slsel_req_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] object_index;
        logic [DATA_W-1:0]  object_x;
        logic [COUNT_W-1:0] hit_count;
        logic               last;
    } slsel_res_t;

    typedef struct packed {
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] x;
    } attr_entry_t;

    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic [DATA_W-1:0]  x;
    } hit_t;

    typedef struct packed {
        logic clear;
        logic insert;
    } list_ctl_t;

endpackage

// ===== rtl/core/slsel_attr_mem.sv =====
`timescale 1ns / 1ps

module slsel_attr_mem (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [slsel_pkg::ENTRY_W-1:0] wr_entry,
    input  logic [1:0]                   wr_lane,
    input  logic [slsel_pkg::DATA_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [slsel_pkg::ENTRY_W-1:0] rd_entry,
    output slsel_pkg::attr_entry_t       rd_data
);
    import slsel_pkg::*;

    // Only the Y and X bytes of an entry are ever read, so only they are stored.
    attr_entry_t attr_mem [TABLE_ENTRIES];
    attr_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (wr_lane)
                LANE_Y:  attr_mem[wr_entry].y <= wr_data;
                LANE_X:  attr_mem[wr_entry].x <= wr_data;
                default: ;
            endcase
        end
        if (rd_en) begin
            rd_data_reg <= attr_mem[rd_entry];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/slsel_hit_list.sv =====
`timescale 1ns / 1ps

module slsel_hit_list (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  slsel_pkg::list_ctl_t          ctl,
    input  slsel_pkg::hit_t               new_hit,
    input  logic [slsel_pkg::LIST_W-1:0]  rd_sel,
    output slsel_pkg::hit_t               rd_hit,
    output logic [slsel_pkg::COUNT_W-1:0] count
);
    import slsel_pkg::*;

    hit_t               list_reg [MAX_PER_LINE];
    hit_t               list_next [MAX_PER_LINE];
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic [MAX_PER_LINE-1:0] shift;

    // Hits arrive in index order; a new one goes behind every held entry
    // whose X is not greater, which keeps equal X values in index order.
    always_comb begin
        for (int j = 0; j < MAX_PER_LINE; j++) begin
            shift[j] = (COUNT_W'(j) < cnt_reg) && (list_reg[j].x > new_hit.x);
        end
        for (int j = 0; j < MAX_PER_LINE; j++) begin
            if (j > 0 && shift[(j > 0) ? j - 1 : 0]) begin
                list_next[j] = list_reg[(j > 0) ? j - 1 : 0];
            end else if (COUNT_W'(j) == cnt_reg || shift[j]) begin
                list_next[j] = new_hit;
            end else begin
                list_next[j] = list_reg[j];
            end
        end
        cnt_next = cnt_reg;
        if (ctl.clear) begin
            cnt_next = '0;
        end else if (ctl.insert) begin
            cnt_next = cnt_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.insert && !ctl.clear) begin
            for (int j = 0; j < MAX_PER_LINE; j++) begin
                list_reg[j] <= list_next[j];
            end
        end
    end

    assign rd_hit = list_reg[rd_sel];
    assign count  = cnt_reg;

endmodule

// ===== rtl/core/sprite_line_selector_unit.sv =====
`timescale 1ns / 1ps
`include "sprite_line_selector_unit_assert.svh"

// Sprite line selector. The block keeps an object attribute table of 40
// four-byte entries, loaded one byte per write request, and answers scan
// requests with the objects that cover the requested line (Y byte minus 16,
// 8 or 16 rows tall as set by the tall_reg register on the cfg channel).
// At most 10 objects are selected, the first ones in entry order, and they
// come out sorted by X byte, equal X values in entry order, one result per
// object with last set on the final one; a line with no object gives a single
// result with found cleared. A scan request reads the table through its single
// read port at one entry per cycle, stopping early once 10 objects are found,
// followed by one result per cycle as the results are taken. The input side
// is closed while a scan is in progress; the final result waits in the output
// register while the next request is already accepted. The table itself has
// no reset: scanning an entry that was never written gives undefined results
// for that entry.

module sprite_line_selector_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  slsel_pkg::slsel_req_t s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output slsel_pkg::slsel_res_t m_data
);
    import slsel_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic                 tall_reg, tall_next;
    logic [IDX_CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ENTRY_W-1:0]   pend_entry_reg, pend_entry_next;
    logic [POS_W-1:0]     target_reg, target_next;
    logic [LIST_W-1:0]    k_reg, k_next;
    logic                 m_valid_reg, m_valid_next;
    slsel_res_t           m_data_reg, m_data_next;

    logic               s_accept;
    logic               wr_en;
    logic               rd_en;
    attr_entry_t        rd_data;
    list_ctl_t          list_ctl;
    hit_t               new_hit;
    hit_t               rd_hit;
    logic [COUNT_W-1:0] hit_cnt;
    logic [POS_W-1:0]   y_low;
    logic [POS_W-1:0]   y_high;
    logic               is_hit;
    logic               list_full;
    logic               scan_done;
    logic               out_load;
    logic               emit_last;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;

    // Writes beyond the table are dropped; bytes 2 and 3 of an entry are never
    // read back, so the memory keeps only the Y and X lanes.
    assign wr_en = s_accept && (s_data.op == OP_WRITE)
                   && (s_data.attr_addr < ADDR_W'(TABLE_BYTES));

    assign rd_en = (state_reg == ST_SCAN) && (rd_idx_reg < IDX_CNT_W'(TABLE_ENTRIES));

    slsel_attr_mem u_attr_mem (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_entry (s_data.attr_addr[ENTRY_W+1:2]),
        .wr_lane  (s_data.attr_addr[1:0]),
        .wr_data  (s_data.attr_data),
        .rd_en    (rd_en),
        .rd_entry (rd_idx_reg[ENTRY_W-1:0]),
        .rd_data  (rd_data)
    );

    // Row test on the entry that comes back from the memory this cycle.
    assign y_low  = {1'b0, rd_data.y};
    assign y_high = y_low + (tall_reg ? POS_W'(TALL_HEIGHT - 1) : POS_W'(SHORT_HEIGHT - 1));
    assign is_hit = (y_low <= target_reg) && (target_reg <= y_high);

    assign list_full = (hit_cnt == COUNT_W'(MAX_PER_LINE));

    assign list_ctl.clear  = s_accept && (s_data.op == OP_SCAN);
    assign list_ctl.insert = (state_reg == ST_SCAN) && pend_valid_reg && is_hit && !list_full;
    assign new_hit.idx     = INDEX_W'(pend_entry_reg);
    assign new_hit.x       = rd_data.x;

    slsel_hit_list u_hit_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (list_ctl),
        .new_hit (new_hit),
        .rd_sel  (k_reg),
        .rd_hit  (rd_hit),
        .count   (hit_cnt)
    );

    // The scan ends once every entry has been read and tested, or as soon as
    // the list is full; a read still in flight at that point is ignored.
    assign scan_done = ((rd_idx_reg == IDX_CNT_W'(TABLE_ENTRIES)) && !pend_valid_reg)
                       || list_full;

    assign out_load  = !m_valid_reg || m_ready;
    assign emit_last = (hit_cnt == '0) || (COUNT_W'(k_reg) == hit_cnt - COUNT_W'(1));

    always_comb begin
        state_next      = state_reg;
        tall_next       = tall_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = rd_en;
        pend_entry_next = rd_idx_reg[ENTRY_W-1:0];
        target_next     = target_reg;
        k_next          = k_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            tall_next = cfg_data;
        end

        if (rd_en) begin
            rd_idx_next = rd_idx_reg + IDX_CNT_W'(1);
        end

        if (out_load) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_data.op == OP_SCAN)) begin
                    target_next = {1'b0, s_data.line} + POS_W'(LINE_OFFSET);
                    rd_idx_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    if (hit_cnt == '0) begin
                        m_data_next = '0;
                    end else begin
                        m_data_next.found        = 1'b1;
                        m_data_next.object_index = rd_hit.idx;
                        m_data_next.object_x     = rd_hit.x;
                        m_data_next.hit_count    = hit_cnt;
                    end
                    m_data_next.last = emit_last;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + LIST_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tall_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tall_reg       <= tall_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        pend_entry_reg <= pend_entry_next;
        target_reg     <= target_next;
        k_reg          <= k_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The selection list never grows past its capacity.
    `SLSEL_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, hit_cnt <= COUNT_W'(MAX_PER_LINE), "hit list overflow")

    // A scan request closes the input side on the following cycle.
    `SLSEL_ASSERT_NEXT(a_scan_blocks, aclk, aresetn, s_accept && (s_data.op == OP_SCAN), !s_ready, "input open during scan")

    // An empty result is always the single, final result of its scan.
    `SLSEL_ASSERT_NOW(a_empty_result, aclk, aresetn, m_valid && !m_data.found, m_data.last && (m_data.hit_count == '0), "malformed empty result")

    // A write request never leaves the idle state.
    `SLSEL_ASSERT_NEXT(a_write_idle, aclk, aresetn, s_accept && (s_data.op == OP_WRITE), s_ready, "write left idle")

endmodule

// ===== bench/sprite_line_selector_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sprite line selector. Requests go in through a
// queue that the stimulus process fills and a clocked driver empties; a clocked
// monitor keeps its own copy of the attribute table and the height setting,
// works out the selected objects of every scan request it sees accepted, and
// compares each result against the oldest outstanding expectation.
module sprite_line_selector_unit_test;
    import slsel_pkg::*;

    localparam int RESET_CYCLES  = 9;
    // This covers a whole scan with room to spare.
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 800000;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    slsel_req_t s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    slsel_res_t m_data;

    // Requests waiting to be driven, and the results still owed by the block.
    slsel_req_t pending_reqs[$];
    slsel_res_t expected_objects[$];

    // The monitor's own view of the block's state.
    logic [DATA_W-1:0] shadow_attr [TABLE_BYTES] = '{default: '0};
    logic              tall_shadow = 1'b0;

    // Height setting as last written by the stimulus process.
    logic tall_now = 1'b0;
    logic idle_on  = 1'b1;

    int req_issued     = 0;
    int req_done       = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    sprite_line_selector_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    function automatic logic [DATA_W-1:0] object_x_of(input logic [INDEX_W-1:0] idx);
        return shadow_attr[4 * idx + int'(LANE_X)];
    endfunction

    // Walks the table in entry order, keeps the first objects that cover the
    // line, sorts them by X byte with ties left in entry order, and queues one
    // expected result per object (or a single empty result).
    function automatic void predict_line_objects(input logic [LINE_W-1:0] scan_line);
        logic [INDEX_W-1:0] picked [MAX_PER_LINE];
        logic [INDEX_W-1:0] moving;
        int unsigned        height;
        int unsigned        target;
        int unsigned        y_top;
        int                 hits;
        int                 j;
        slsel_res_t         res;

        height = tall_shadow ? TALL_HEIGHT : SHORT_HEIGHT;
        // The offset is added in full width, so lines near the top never wrap.
        target = scan_line + LINE_OFFSET;
        hits   = 0;
        for (int e = 0; e < TABLE_ENTRIES && hits < MAX_PER_LINE; e++) begin
            y_top = shadow_attr[4 * e + int'(LANE_Y)];
            if (y_top <= target && target <= y_top + height - 1) begin
                picked[hits] = INDEX_W'(e);
                hits++;
            end
        end

        for (int i = 1; i < hits; i++) begin
            moving = picked[i];
            j = i;
            while (j > 0 && object_x_of(picked[j - 1]) > object_x_of(moving)) begin
                picked[j] = picked[j - 1];
                j--;
            end
            picked[j] = moving;
        end

        if (hits == 0) begin
            res      = '0;
            res.last = 1'b1;
            expected_objects.insert(expected_objects.size(), res);
        end else begin
            for (int k = 0; k < hits; k++) begin
                res.found        = 1'b1;
                res.object_index = picked[k];
                res.object_x     = object_x_of(picked[k]);
                res.hit_count    = COUNT_W'(hits);
                res.last         = (k == hits - 1);
                expected_objects.insert(expected_objects.size(), res);
            end
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Monitor: everything is sampled at the rising edge. Results are checked
    // before a request accepted on the same edge is predicted, although such a
    // result always belongs to an earlier scan anyway.
    always @(posedge aclk) begin
        slsel_res_t want;

        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_objects.size() == 0) begin
                    $error("result with no scan outstanding: %p", m_data);
                    mismatch_count++;
                end else begin
                    want = expected_objects[0];
                    expected_objects.delete(0);
                    check_field("found", want.found, m_data.found);
                    check_field("object_index", want.object_index, m_data.object_index);
                    check_field("object_x", want.object_x, m_data.object_x);
                    check_field("hit_count", want.hit_count, m_data.hit_count);
                    check_field("last", want.last, m_data.last);
                end
            end
            if (s_valid && s_ready) begin
                req_done <= req_done + 1;
                if (s_data.op == OP_WRITE) begin
                    // Addresses beyond the table are dropped by the block.
                    if (s_data.attr_addr < TABLE_BYTES) begin
                        shadow_attr[s_data.attr_addr] = s_data.attr_data;
                    end
                end else begin
                    predict_line_objects(s_data.line);
                end
            end
            if (cfg_valid && cfg_ready) begin
                tall_shadow = cfg_data;
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Request driver: holds a request until it is taken, then either idles for
    // a random burst or presents the next request from the queue.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && req_done != req_issued) begin
            // The current request has not been taken yet, so it stays as it is.
        end else if (send_gap > 0) begin
            s_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid  <= 1'b0;
            send_gap <= $urandom_range(0, 15);
        end else if (pending_reqs.size() != 0) begin
            s_valid    <= 1'b1;
            s_data     <= pending_reqs[0];
            pending_reqs.delete(0);
            req_issued <= req_issued + 1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result sink: ready most of the time, with random stall bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Unused fields of each request carry random values so that every payload
    // bit is exercised.
    function automatic void queue_write(input int addr, input int data);
        slsel_req_t req;

        req.op        = OP_WRITE;
        req.attr_addr = ADDR_W'(addr);
        req.attr_data = DATA_W'(data);
        req.line      = LINE_W'($urandom_range(0, 255));
        pending_reqs.insert(pending_reqs.size(), req);
    endfunction

    function automatic void queue_scan(input int scan_line);
        slsel_req_t req;

        req.op        = OP_SCAN;
        req.attr_addr = ADDR_W'($urandom_range(0, 255));
        req.attr_data = DATA_W'($urandom_range(0, 255));
        req.line      = LINE_W'(scan_line);
        pending_reqs.insert(pending_reqs.size(), req);
    endfunction

    // Waits until every request has been taken and every result has arrived,
    // then lets a scan's worth of cycles pass so that a trailing write is done.
    task automatic wait_drained();
        @(posedge aclk);
        while (pending_reqs.size() != 0 || req_done != req_issued
               || expected_objects.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tall(input logic value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
        tall_now = value;
    endtask

    // Random traffic. Most of it is loose writes and scans; a good share is a
    // crowd: several entries placed around one line, with X values drawn from
    // a few values so that ties occur, followed by a scan of that line. Crowds
    // on top of earlier traffic regularly push a line past ten objects.
    task automatic queue_random_items(input int want);
        int made;
        int pick;
        int base;
        int crowd;
        int entry;
        int lane;
        int height;

        made   = 0;
        height = tall_now ? TALL_HEIGHT : SHORT_HEIGHT;
        while (made < want) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                queue_write($urandom_range(TABLE_BYTES, 255), $urandom_range(0, 255));
                made++;
            end else if (pick < 40) begin
                if ($urandom_range(0, 7) == 0) begin
                    queue_scan($urandom_range(0, 255));
                end else begin
                    queue_scan($urandom_range(0, 153));
                end
                made++;
            end else if (pick < 55) begin
                base  = $urandom_range(0, 153);
                crowd = $urandom_range(2, 12);
                repeat (crowd) begin
                    entry = $urandom_range(0, TABLE_ENTRIES - 1);
                    queue_write(4 * entry + int'(LANE_Y),
                                base + LINE_OFFSET - $urandom_range(0, height - 1));
                    if ($urandom_range(0, 3) == 0) begin
                        queue_write(4 * entry + int'(LANE_X), $urandom_range(0, 255));
                    end else begin
                        queue_write(4 * entry + int'(LANE_X), 8 * $urandom_range(0, 5));
                    end
                end
                queue_scan(base);
                made += 2 * crowd + 1;
            end else begin
                entry = $urandom_range(0, TABLE_ENTRIES - 1);
                lane  = $urandom_range(0, 3);
                if (lane == int'(LANE_Y) && $urandom_range(0, 3) != 0) begin
                    queue_write(4 * entry + lane, $urandom_range(8, 175));
                end else begin
                    queue_write(4 * entry + lane, $urandom_range(0, 255));
                end
                made++;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Load the whole table first, so that no scan ever reads a byte that was
        // never written. All Y bytes start at zero, which no line can reach.
        for (int b = 0; b < TABLE_BYTES; b++) begin
            if (b % 4 == int'(LANE_Y)) begin
                queue_write(b, 0);
            end else begin
                queue_write(b, $urandom_range(0, 255));
            end
        end

        // Directed part, 8-row objects: a line with nothing on it, the last
        // byte of the table and writes beyond it, a tie on X, and an object at
        // the bottom of the Y range.
        queue_scan(0);
        queue_scan(153);
        queue_write(TABLE_BYTES - 1, 8'hFF);
        queue_write(TABLE_BYTES, 8'hA5);
        queue_write(255, 8'h5A);
        queue_write(4 * 3 + int'(LANE_Y), 16);
        queue_write(4 * 3 + int'(LANE_X), 8);
        queue_write(4 * 5 + int'(LANE_Y), 16);
        queue_write(4 * 5 + int'(LANE_X), 8);
        queue_write(4 * 1 + int'(LANE_Y), 20);
        queue_write(4 * 1 + int'(LANE_X), 0);
        queue_scan(4);
        queue_scan(0);
        queue_scan(11);
        queue_write(4 * (TABLE_ENTRIES - 1) + int'(LANE_Y), 255);
        queue_write(4 * (TABLE_ENTRIES - 1) + int'(LANE_X), 255);
        queue_scan(239);
        queue_scan(255);
        wait_drained();

        // Same table with 16-row objects: lines 11 and 254 now catch more.
        write_tall(1'b1);
        queue_scan(11);
        queue_scan(254);
        queue_scan(255);
        queue_random_items(60);
        wait_drained();

        write_tall(1'b0);
        queue_random_items(50);
        wait_drained();

        write_tall(1'b1);
        queue_random_items(35);
        wait_drained();

        // The last stretch runs with both sides at full rate.
        idle_on = 1'b0;
        queue_random_items(25);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
